// File: hdl/led_blk_pkg.sv
package led_blk_pkg;

    localparam int ACTION_W   = 4;
    localparam int LEVEL_W    = 8;
    localparam int COUNT_W    = 16;
    localparam int DURATION_W = 24;

    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 16;

    localparam logic [ACTION_W-1:0] ACT_TICK_MS       = 4'd0;
    localparam logic [ACTION_W-1:0] ACT_ON            = 4'd1;
    localparam logic [ACTION_W-1:0] ACT_OFF           = 4'd2;
    localparam logic [ACTION_W-1:0] ACT_TOGGLE        = 4'd3;
    localparam logic [ACTION_W-1:0] ACT_SET_LEVEL     = 4'd4;
    localparam logic [ACTION_W-1:0] ACT_BLINK_N       = 4'd5;
    localparam logic [ACTION_W-1:0] ACT_BLINK_TIMED   = 4'd6;
    localparam logic [ACTION_W-1:0] ACT_BLINK_FOREVER = 4'd7;
    localparam logic [ACTION_W-1:0] ACT_STOP          = 4'd8;

    localparam logic [LEVEL_W-1:0]    FULL_LEVEL   = 8'd255;
    localparam logic [COUNT_W-1:0]    COUNT_MAX    = 16'hFFFF;
    localparam logic [DURATION_W-1:0] DURATION_MAX = 24'hFFFFFF;

endpackage

// File: hdl/led_blink_controller.sv
// Channel  | Port group              | Contents
// ---------+-------------------------+------------------------------------------
// Input    | s_tvalid/s_tready       | tuser: action; tdata: level, times,
//          | s_tdata/s_tuser         |   interval, duration
// Output   | m_tvalid/m_tready       | tdata: pwm_level, lit, blinking,
//          | m_tdata                 |   state_changed, blink_ended
//
// One transaction in, one transaction out. A transaction is held in an input
// register, then the counter and level update runs and its result lands in the
// output register: one transaction per cycle while m_tready does not stall the
// output. Reset (aresetn low, synchronous) returns the LED to off and idle and
// empties both registers. A stall on m_tready holds the output register; the input
// register keeps accepting as long as its transaction can move on.
module led_blink_controller (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] level, [23:8] times, [39:24] interval, [63:40] duration
    input  logic [led_blk_pkg::S_TDATA_W-1:0] s_tdata,
    // [3:0] action
    input  logic [led_blk_pkg::S_TUSER_W-1:0] s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] pwm_level, [8] lit, [9] blinking, [10] state_changed,
    // [11] blink_ended, [15:12] zero
    output logic [led_blk_pkg::M_TDATA_W-1:0] m_tdata
);

    // Input register
    logic                                   in_valid_reg;
    logic [led_blk_pkg::ACTION_W-1:0]       act_reg;
    logic [led_blk_pkg::LEVEL_W-1:0]        level_reg;
    logic [led_blk_pkg::COUNT_W-1:0]        times_reg;
    logic [led_blk_pkg::COUNT_W-1:0]        interval_reg;
    logic [led_blk_pkg::DURATION_W-1:0]     duration_reg;

    // Controller state
    logic [led_blk_pkg::LEVEL_W-1:0]    duty_reg, duty_next;
    logic                               active_reg, active_next;
    logic                               forever_reg, forever_next;
    logic                               timed_reg, timed_next;
    logic [led_blk_pkg::COUNT_W-1:0]    target_edges_reg, target_edges_next;
    logic [led_blk_pkg::COUNT_W-1:0]    edges_done_reg, edges_done_next;
    logic [led_blk_pkg::COUNT_W-1:0]    toggle_period_reg, toggle_period_next;
    logic [led_blk_pkg::COUNT_W-1:0]    since_toggle_reg, since_toggle_next;
    logic [led_blk_pkg::DURATION_W-1:0] time_limit_reg, time_limit_next;
    logic [led_blk_pkg::DURATION_W-1:0] since_start_reg, since_start_next;

    // Output register
    logic                               out_valid_reg;
    logic [led_blk_pkg::M_TDATA_W-1:0]  out_data_reg;

    logic                               advance;
    logic                               fire;
    logic                               announced;
    logic                               ended;
    logic                               finite;
    logic [led_blk_pkg::COUNT_W-1:0]    toggle_inc;
    logic [led_blk_pkg::DURATION_W-1:0] start_inc;
    logic [led_blk_pkg::COUNT_W-1:0]    edges_inc;
    logic                               lit_now;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Saturating counters advanced by a tick.
    assign toggle_inc = (since_toggle_reg == led_blk_pkg::COUNT_MAX) ?
                        since_toggle_reg : since_toggle_reg + 16'd1;
    assign start_inc  = (since_start_reg == led_blk_pkg::DURATION_MAX) ?
                        since_start_reg : since_start_reg + 24'd1;
    assign finite     = !forever_reg && !timed_reg;
    // An off edge only counts in finite mode, and only when the LED was lit.
    assign edges_inc  = (finite && duty_reg != '0 &&
                         edges_done_reg != led_blk_pkg::COUNT_MAX) ?
                        edges_done_reg + 16'd1 : edges_done_reg;
    assign lit_now    = (duty_next != '0);

    always_comb begin
        duty_next          = duty_reg;
        active_next        = active_reg;
        forever_next       = forever_reg;
        timed_next         = timed_reg;
        target_edges_next  = target_edges_reg;
        edges_done_next    = edges_done_reg;
        toggle_period_next = toggle_period_reg;
        since_toggle_next  = since_toggle_reg;
        time_limit_next    = time_limit_reg;
        since_start_next   = since_start_reg;
        announced          = 1'b0;
        ended              = 1'b0;

        case (act_reg)
            led_blk_pkg::ACT_TICK_MS: begin
                if (active_reg) begin
                    since_toggle_next = toggle_inc;
                    since_start_next  = start_inc;
                    if (toggle_inc >= toggle_period_reg) begin
                        since_toggle_next = '0;
                        edges_done_next   = edges_inc;
                        duty_next         = (duty_reg != '0) ? '0 : led_blk_pkg::FULL_LEVEL;
                        announced         = 1'b1;
                        if (finite && edges_inc >= target_edges_reg) begin
                            active_next  = 1'b0;
                            forever_next = 1'b0;
                            duty_next    = '0;
                            ended        = 1'b1;
                        end
                    end
                    if (timed_reg && start_inc >= time_limit_reg) begin
                        active_next  = 1'b0;
                        forever_next = 1'b0;
                        timed_next   = 1'b0;
                        duty_next    = '0;
                        announced    = 1'b1;
                        ended        = 1'b1;
                    end
                end
            end
            led_blk_pkg::ACT_ON: begin
                duty_next = led_blk_pkg::FULL_LEVEL;
                announced = 1'b1;
            end
            led_blk_pkg::ACT_OFF: begin
                duty_next = '0;
                announced = 1'b1;
            end
            led_blk_pkg::ACT_TOGGLE: begin
                duty_next = (duty_reg != '0) ? '0 : led_blk_pkg::FULL_LEVEL;
                announced = 1'b1;
            end
            led_blk_pkg::ACT_SET_LEVEL: begin
                duty_next = level_reg;
                announced = 1'b1;
            end
            led_blk_pkg::ACT_BLINK_N: begin
                active_next        = 1'b1;
                forever_next       = 1'b0;
                timed_next         = 1'b0;
                target_edges_next  = times_reg;
                toggle_period_next = interval_reg;
                edges_done_next    = '0;
                since_toggle_next  = '0;
            end
            led_blk_pkg::ACT_BLINK_TIMED: begin
                active_next        = 1'b1;
                forever_next       = 1'b0;
                timed_next         = 1'b1;
                time_limit_next    = duration_reg;
                toggle_period_next = interval_reg;
                edges_done_next    = '0;
                since_toggle_next  = '0;
                since_start_next   = '0;
            end
            led_blk_pkg::ACT_BLINK_FOREVER: begin
                active_next        = 1'b1;
                forever_next       = 1'b1;
                timed_next         = 1'b0;
                toggle_period_next = interval_reg;
                since_toggle_next  = '0;
            end
            led_blk_pkg::ACT_STOP: begin
                // Timed mode is left as it is; the tick path and the other blink commands clear it.
                active_next  = 1'b0;
                forever_next = 1'b0;
                duty_next    = '0;
                announced    = 1'b1;
                ended        = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            act_reg      <= s_tuser[3:0];
            level_reg    <= s_tdata[7:0];
            times_reg    <= s_tdata[23:8];
            interval_reg <= s_tdata[39:24];
            duration_reg <= s_tdata[63:40];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duty_reg          <= '0;
            active_reg        <= 1'b0;
            forever_reg       <= 1'b0;
            timed_reg         <= 1'b0;
            target_edges_reg  <= '0;
            edges_done_reg    <= '0;
            toggle_period_reg <= '0;
            since_toggle_reg  <= '0;
            time_limit_reg    <= '0;
            since_start_reg   <= '0;
        end else if (fire) begin
            duty_reg          <= duty_next;
            active_reg        <= active_next;
            forever_reg       <= forever_next;
            timed_reg         <= timed_next;
            target_edges_reg  <= target_edges_next;
            edges_done_reg    <= edges_done_next;
            toggle_period_reg <= toggle_period_next;
            since_toggle_reg  <= since_toggle_next;
            time_limit_reg    <= time_limit_next;
            since_start_reg   <= since_start_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
        if (fire) begin
            out_data_reg <= {4'd0, ended, announced, active_next, lit_now, duty_next};
        end
    end

endmodule

// File: hdl/led_blk_checker.sv
module led_blk_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [led_blk_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [led_blk_pkg::S_TUSER_W-1:0] s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [led_blk_pkg::M_TDATA_W-1:0] m_tdata
);

    // A result that is not taken must stay put.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The lit flag always follows the level.
    a_lit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[8] == (m_tdata[7:0] != 8'd0)))
        else $error("lit flag disagrees with pwm level");

    // Ending a blink forces the LED dark and idle.
    a_end_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[11] |-> m_tdata[7:0] == 8'd0 && !m_tdata[9])
        else $error("blink ended but LED still lit or blinking");

    // Ending a blink always announces the new lit state.
    a_end_announce: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[11] |-> m_tdata[10])
        else $error("blink ended without state change");

    // The output is empty right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind led_blink_controller led_blk_checker u_led_blk_checker (.*);

// File: tb/led_blink_controller_tb.sv
module led_blink_controller_tb;

    // Action codes past the stop command are reserved and must leave the state alone.
    localparam logic [led_blk_pkg::ACTION_W-1:0] ACT_RSVD_FIRST = 4'd9;
    localparam logic [led_blk_pkg::ACTION_W-1:0] ACT_RSVD_LAST  = 4'd15;

    localparam int RANDOM_ITEMS = 1500;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 20;

    typedef struct {
        logic [led_blk_pkg::ACTION_W-1:0]   action;
        logic [led_blk_pkg::LEVEL_W-1:0]    level;
        logic [led_blk_pkg::COUNT_W-1:0]    times;
        logic [led_blk_pkg::COUNT_W-1:0]    interval;
        logic [led_blk_pkg::DURATION_W-1:0] duration;
    } led_cmd_t;

    typedef struct {
        logic [led_blk_pkg::LEVEL_W-1:0] pwm;
        logic                            lit;
        logic                            blinking;
        logic                            changed;
        logic                            ended;
    } led_out_t;

    typedef struct {
        led_cmd_t cmd;
        bit       typed;
        led_out_t want;
    } led_row_t;

    logic                               aclk     = 1'b0;
    logic                               aresetn  = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [led_blk_pkg::S_TDATA_W-1:0]  s_tdata  = '0;
    logic [led_blk_pkg::S_TUSER_W-1:0]  s_tuser  = '0;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [led_blk_pkg::M_TDATA_W-1:0]  m_tdata;

    led_out_t expected_lamp_q[$];
    led_row_t directed_q[$];
    int       fail_count = 0;
    int       burst_left = 0;

    // Predicted LED and blink timer state.
    logic [led_blk_pkg::LEVEL_W-1:0]    lamp_level;
    logic                               lamp_lit;
    logic                               blink_on;
    logic                               blink_forever_f;
    logic                               blink_timed_f;
    logic [led_blk_pkg::COUNT_W-1:0]    edge_target;
    logic [led_blk_pkg::COUNT_W-1:0]    edge_count;
    logic [led_blk_pkg::COUNT_W-1:0]    period_ms;
    logic [led_blk_pkg::COUNT_W-1:0]    toggle_age;
    logic [led_blk_pkg::DURATION_W-1:0] time_budget;
    logic [led_blk_pkg::DURATION_W-1:0] blink_age;
    logic                               pulse_changed;
    logic                               pulse_ended;

    led_blink_controller u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        #(12 * 2_000_000);
        $display("TEST FAILED");
        $finish;
    end

    task automatic lamp_clear();
        lamp_level      = '0;
        lamp_lit        = 1'b0;
        blink_on        = 1'b0;
        blink_forever_f = 1'b0;
        blink_timed_f   = 1'b0;
        edge_target     = '0;
        edge_count      = '0;
        period_ms       = '0;
        toggle_age      = '0;
        time_budget     = '0;
        blink_age       = '0;
    endtask

    task automatic lamp_drive(input logic [led_blk_pkg::LEVEL_W-1:0] v);
        lamp_level    = v;
        lamp_lit      = (v != '0);
        pulse_changed = 1'b1;
    endtask

    task automatic blink_halt();
        blink_on        = 1'b0;
        blink_forever_f = 1'b0;
        lamp_drive('0);
        pulse_ended     = 1'b1;
    endtask

    task automatic lamp_tick();
        logic finite;
        if (!blink_on) return;
        if (toggle_age != led_blk_pkg::COUNT_MAX) toggle_age++;
        if (blink_age != led_blk_pkg::DURATION_MAX) blink_age++;
        finite = !blink_forever_f && !blink_timed_f;
        if (toggle_age >= period_ms) begin
            toggle_age = '0;
            if (lamp_lit) begin
                lamp_drive('0);
                // Only the finite mode counts off edges.
                if (finite && edge_count != led_blk_pkg::COUNT_MAX) edge_count++;
            end else begin
                lamp_drive(led_blk_pkg::FULL_LEVEL);
            end
            if (finite && edge_count >= edge_target) blink_halt();
        end
        if (blink_timed_f && blink_age >= time_budget) begin
            blink_halt();
            blink_timed_f = 1'b0;
        end
    endtask

    task automatic lamp_predict(input led_cmd_t c, output led_out_t r);
        pulse_changed = 1'b0;
        pulse_ended   = 1'b0;
        case (c.action)
            led_blk_pkg::ACT_TICK_MS:   lamp_tick();
            led_blk_pkg::ACT_ON:        lamp_drive(led_blk_pkg::FULL_LEVEL);
            led_blk_pkg::ACT_OFF:       lamp_drive('0);
            led_blk_pkg::ACT_TOGGLE:    lamp_drive(lamp_lit ? '0 : led_blk_pkg::FULL_LEVEL);
            led_blk_pkg::ACT_SET_LEVEL: lamp_drive(c.level);
            led_blk_pkg::ACT_BLINK_N: begin
                blink_on        = 1'b1;
                blink_forever_f = 1'b0;
                blink_timed_f   = 1'b0;
                edge_target     = c.times;
                period_ms       = c.interval;
                edge_count      = '0;
                toggle_age      = '0;
            end
            led_blk_pkg::ACT_BLINK_TIMED: begin
                blink_on        = 1'b1;
                blink_forever_f = 1'b0;
                blink_timed_f   = 1'b1;
                time_budget     = c.duration;
                period_ms       = c.interval;
                edge_count      = '0;
                toggle_age      = '0;
                blink_age       = '0;
            end
            led_blk_pkg::ACT_BLINK_FOREVER: begin
                blink_on        = 1'b1;
                blink_forever_f = 1'b1;
                blink_timed_f   = 1'b0;
                period_ms       = c.interval;
                toggle_age      = '0;
            end
            led_blk_pkg::ACT_STOP:      blink_halt();
            default: ;
        endcase
        r.pwm      = lamp_level;
        r.lit      = lamp_lit;
        r.blinking = blink_on;
        r.changed  = pulse_changed;
        r.ended    = pulse_ended;
    endtask

    function automatic led_cmd_t make_cmd(logic [led_blk_pkg::ACTION_W-1:0] a,
                                          logic [led_blk_pkg::LEVEL_W-1:0] lv,
                                          logic [led_blk_pkg::COUNT_W-1:0] tm,
                                          logic [led_blk_pkg::COUNT_W-1:0] iv,
                                          logic [led_blk_pkg::DURATION_W-1:0] du);
        led_cmd_t c;
        c.action   = a;
        c.level    = lv;
        c.times    = tm;
        c.interval = iv;
        c.duration = du;
        return c;
    endfunction

    task automatic row_pred(logic [led_blk_pkg::ACTION_W-1:0] a,
                            logic [led_blk_pkg::LEVEL_W-1:0] lv,
                            logic [led_blk_pkg::COUNT_W-1:0] tm,
                            logic [led_blk_pkg::COUNT_W-1:0] iv,
                            logic [led_blk_pkg::DURATION_W-1:0] du);
        led_row_t row;
        row.cmd   = make_cmd(a, lv, tm, iv, du);
        row.typed = 1'b0;
        row.want  = '{default: '0};
        directed_q.push_back(row);
    endtask

    task automatic row_fixed(logic [led_blk_pkg::ACTION_W-1:0] a,
                             logic [led_blk_pkg::LEVEL_W-1:0] lv,
                             logic [led_blk_pkg::COUNT_W-1:0] tm,
                             logic [led_blk_pkg::COUNT_W-1:0] iv,
                             logic [led_blk_pkg::DURATION_W-1:0] du,
                             logic [led_blk_pkg::LEVEL_W-1:0] pwm,
                             logic lit, logic blinking, logic changed, logic ended);
        led_row_t row;
        row.cmd           = make_cmd(a, lv, tm, iv, du);
        row.typed         = 1'b1;
        row.want.pwm      = pwm;
        row.want.lit      = lit;
        row.want.blinking = blinking;
        row.want.changed  = changed;
        row.want.ended    = ended;
        directed_q.push_back(row);
    endtask

    task automatic build_directed();
        // Idle and manual control.
        row_fixed(led_blk_pkg::ACT_TICK_MS,   8'hFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF,
                  8'd0,   1'b0, 1'b0, 1'b0, 1'b0);
        row_fixed(ACT_RSVD_LAST,              8'h00, 16'h0000, 16'h0000, 24'h000000,
                  8'd0,   1'b0, 1'b0, 1'b0, 1'b0);
        row_fixed(led_blk_pkg::ACT_ON,        8'h00, 16'h0000, 16'h0000, 24'h000000,
                  8'd255, 1'b1, 1'b0, 1'b1, 1'b0);
        row_fixed(led_blk_pkg::ACT_SET_LEVEL, 8'h00, 16'h0000, 16'h0000, 24'h000000,
                  8'd0,   1'b0, 1'b0, 1'b1, 1'b0);
        row_fixed(led_blk_pkg::ACT_SET_LEVEL, 8'hFF, 16'h0000, 16'h0000, 24'h000000,
                  8'd255, 1'b1, 1'b0, 1'b1, 1'b0);
        row_fixed(led_blk_pkg::ACT_TOGGLE,    8'h00, 16'h0000, 16'h0000, 24'h000000,
                  8'd0,   1'b0, 1'b0, 1'b1, 1'b0);
        row_fixed(led_blk_pkg::ACT_TOGGLE,    8'h00, 16'h0000, 16'h0000, 24'h000000,
                  8'd255, 1'b1, 1'b0, 1'b1, 1'b0);
        row_fixed(led_blk_pkg::ACT_OFF,       8'hFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF,
                  8'd0,   1'b0, 1'b0, 1'b1, 1'b0);
        row_fixed(led_blk_pkg::ACT_STOP,      8'h00, 16'h0000, 16'h0000, 24'h000000,
                  8'd0,   1'b0, 1'b0, 1'b1, 1'b1);
        // Zero times and zero interval: the blink ends at the first tick with the LED dark.
        row_fixed(led_blk_pkg::ACT_BLINK_N,   8'h00, 16'h0000, 16'h0000, 24'h000000,
                  8'd0,   1'b0, 1'b1, 1'b0, 1'b0);
        row_pred(led_blk_pkg::ACT_TICK_MS,     8'h00, 16'h0000, 16'h0000, 24'h000000);
        row_pred(led_blk_pkg::ACT_BLINK_N,     8'h00, 16'd2,    16'd1,    24'h000000);
        repeat (5) row_pred(led_blk_pkg::ACT_TICK_MS, 8'h00, 16'h0000, 16'h0000, 24'h000000);
        // Zero duration stops on the first tick.
        row_pred(led_blk_pkg::ACT_BLINK_TIMED, 8'h00, 16'h0000, 16'hFFFF, 24'h000000);
        row_pred(led_blk_pkg::ACT_TICK_MS,     8'h00, 16'h0000, 16'h0000, 24'h000000);
        row_pred(led_blk_pkg::ACT_BLINK_FOREVER, 8'hFF, 16'hFFFF, 16'h0000, 24'hFFFFFF);
        row_pred(led_blk_pkg::ACT_TICK_MS,     8'h00, 16'h0000, 16'h0000, 24'h000000);
        row_pred(led_blk_pkg::ACT_SET_LEVEL,   8'h5A, 16'h0000, 16'h0000, 24'h000000);
        row_pred(ACT_RSVD_FIRST,               8'hFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
        row_pred(led_blk_pkg::ACT_TICK_MS,     8'h00, 16'h0000, 16'h0000, 24'h000000);
        row_pred(led_blk_pkg::ACT_BLINK_TIMED, 8'h00, 16'h0000, 16'd2,    24'hFFFFFF);
        row_fixed(led_blk_pkg::ACT_STOP,       8'hFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF,
                  8'd0,   1'b0, 1'b0, 1'b1, 1'b1);
    endtask

    function automatic led_cmd_t random_cmd();
        led_cmd_t c;
        int       pick;
        bit       wide;
        c.level    = 8'($urandom);
        c.times    = 16'($urandom);
        c.interval = 16'($urandom);
        c.duration = 24'($urandom);
        pick = $urandom_range(0, 99);
        // Mostly short intervals and counts so that blink runs finish within a few ticks.
        wide = ($urandom_range(0, 7) == 0);
        if (pick < 55) begin
            c.action = led_blk_pkg::ACT_TICK_MS;
        end else if (pick < 62) begin
            c.action = led_blk_pkg::ACT_BLINK_N;
            if (!wide) begin
                c.times    = 16'($urandom_range(0, 6));
                c.interval = 16'($urandom_range(0, 4));
            end
        end else if (pick < 68) begin
            c.action = led_blk_pkg::ACT_BLINK_TIMED;
            if (!wide) begin
                c.duration = 24'($urandom_range(0, 40));
                c.interval = 16'($urandom_range(0, 6));
            end
        end else if (pick < 73) begin
            c.action = led_blk_pkg::ACT_BLINK_FOREVER;
            if (!wide) c.interval = 16'($urandom_range(0, 5));
        end else if (pick < 78) begin
            c.action = led_blk_pkg::ACT_STOP;
        end else if (pick < 82) begin
            c.action = led_blk_pkg::ACT_ON;
        end else if (pick < 86) begin
            c.action = led_blk_pkg::ACT_OFF;
        end else if (pick < 90) begin
            c.action = led_blk_pkg::ACT_TOGGLE;
        end else if (pick < 96) begin
            c.action = led_blk_pkg::ACT_SET_LEVEL;
        end else begin
            c.action = 4'($urandom_range(ACT_RSVD_FIRST, ACT_RSVD_LAST));
        end
        return c;
    endfunction

    task automatic sender_gap();
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
    endtask

    task automatic send_cmd(input led_cmd_t c, input bit typed, input led_out_t want);
        led_out_t model;
        s_tvalid <= 1'b1;
        s_tuser  <= c.action;
        s_tdata  <= {c.duration, c.interval, c.times, c.level};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // The predictor runs on every transaction so its state stays in step.
        lamp_predict(c, model);
        if (typed) expected_lamp_q.push_back(want);
        else expected_lamp_q.push_back(model);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_lamp_q.size() != 0) @(posedge aclk);
    endtask

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        led_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_lamp_q.size() == 0) begin
                $error("result transaction with nothing expected: tdata=%h", m_tdata);
                fail_count++;
            end else begin
                want = expected_lamp_q.pop_front();
                check_field("pwm_level",     want.pwm,      m_tdata[7:0]);
                check_field("lit",           want.lit,      m_tdata[8]);
                check_field("blinking",      want.blinking, m_tdata[9]);
                check_field("state_changed", want.changed,  m_tdata[10]);
                check_field("blink_ended",   want.ended,    m_tdata[11]);
            end
        end
    end

    // The receiver switches between stall patterns chosen at random.
    int rx_cycle = 0;
    int rx_mode  = 0;
    int rx_hold  = 0;

    always @(posedge aclk) begin
        if (rx_cycle % 256 == 0) rx_mode = $urandom_range(0, 3);
        rx_cycle++;
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (rx_cycle % 4 == 3);
            default: begin
                if (rx_hold > 0) begin
                    rx_hold--;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 7) == 0) rx_hold = $urandom_range(1, 15);
                end
            end
        endcase
    end

    initial begin
        led_out_t none;
        int       waited;
        none = '{default: '0};
        lamp_clear();
        build_directed();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_q[i]) begin
            sender_gap();
            send_cmd(directed_q[i].cmd, directed_q[i].typed, directed_q[i].want);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 400 == 399) wait_drained();
            sender_gap();
            send_cmd(random_cmd(), 1'b0, none);
        end
        s_tvalid <= 1'b0;

        waited = 0;
        while (expected_lamp_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_lamp_q.size() != 0) begin
            $error("%0d expected result transactions never arrived", expected_lamp_q.size());
            fail_count++;
        end

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
